### src/pid_servo_duty_controller_top_defines.svh
// assertion macros for the pid servo duty controller checker
`ifndef PID_SERVO_DUTY_CONTROLLER_TOP_DEFINES_SVH
`define PID_SERVO_DUTY_CONTROLLER_TOP_DEFINES_SVH

// condition that must hold at every edge, reset included
`define PSDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

// same-cycle implication outside reset
`define PSDC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication outside reset
`define PSDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/psdc_pkg.sv
// shared types and constants for the pid servo duty controller
`timescale 1ns / 1ps

package psdc_pkg;

    localparam int FIELD_W            = 12;
    localparam int SAMPLE_BITS        = 12;
    localparam int GAIN_W             = 16;
    localparam int DUTY_W             = 12;
    localparam int ERR_W              = SAMPLE_BITS + 1;
    localparam int DERIV_W            = ERR_W + 1;
    localparam int SUM_W              = 32;
    localparam int P_W                = GAIN_W + 1 + ERR_W;
    localparam int I_W                = GAIN_W + 1 + SUM_W;
    localparam int D_W                = GAIN_W + 1 + DERIV_W;
    localparam int ACC_W              = I_W + 2;
    localparam int DEF_GAIN_FRAC_BITS = 12;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 0,
        REG_INTEG_GAIN  = 1,
        REG_DERIV_GAIN  = 2,
        REG_DUTY_CENTER = 3,
        REG_DUTY_MAX    = 4,
        REG_DUTY_MIN    = 5
    } cfg_idx_t;

    typedef struct packed {
        logic [FIELD_W-1:0] setpoint;
        logic [FIELD_W-1:0] position;
    } in_beat_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_us;
        logic              clamped;
    } out_beat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [DUTY_W-1:0] duty_center;
        logic [DUTY_W-1:0] duty_max;
        logic [DUTY_W-1:0] duty_min;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [SUM_W-1:0]   sum;
    } err_beat_t;

    typedef struct packed {
        logic signed [P_W-1:0] p_term;
        logic signed [I_W-1:0] i_term;
        logic signed [D_W-1:0] d_term;
    } prod_beat_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:   16'd778,
        integ_gain:  16'd0,
        deriv_gain:  16'd5939,
        duty_center: 12'd1500,
        duty_max:    12'd2100,
        duty_min:    12'd900
    };

endpackage

### src/pid_servo_duty_controller_top.sv
// top level of one pid servo axis: config registers and the five-stage datapath
`timescale 1ns / 1ps

// one axis of a pid position loop for a servo. each input beat carries a setpoint
// and a measured position; each one yields exactly one output beat with the
// clamped pulse width in microseconds and a flag that the limit was hit. a new
// beat can be taken every clock while the output is not stalled, so the
// sustained rate is one beat per cycle; the loop state (previous error and the
// saturating error sum) is updated as each beat enters the error stage, which
// is what holds the rate at one per clock. the five stages are the input
// register, the error stage, the gain multipliers, the term sum with floor shift,
// and the clamped output register. the user must write gains and duty limits
// through the register port only while the block is idle; it is not enforced.
module pid_servo_duty_controller_top #(
    parameter int GAIN_FRAC_BITS = psdc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [psdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psdc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  psdc_pkg::in_beat_t                in_beat,
    output logic                              out_valid,
    input  logic                              out_stall,
    output psdc_pkg::out_beat_t               out_beat
);
    import psdc_pkg::*;

    cfg_t        cfg;
    logic        in_ready;
    logic        err_valid;
    logic        err_ready;
    err_beat_t   err_beat;
    logic        prod_valid;
    logic        prod_ready;
    prod_beat_t  prod_beat;

    psdc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    psdc_err u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_beat  (in_beat),
        .dn_valid (err_valid),
        .dn_ready (err_ready),
        .dn_beat  (err_beat)
    );

    psdc_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (err_valid),
        .up_ready (err_ready),
        .up_beat  (err_beat),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn_beat  (prod_beat)
    );

    psdc_out #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_beat  (prod_beat),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .dn_beat  (out_beat)
    );

    assign in_stall = !in_ready;

endmodule

### src/psdc_cfg.sv
// configuration register file
`timescale 1ns / 1ps

module psdc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [psdc_pkg::CFG_IDX_W-1:0]    index,
    input  logic [psdc_pkg::CFG_DATA_W-1:0]   data,
    output psdc_pkg::cfg_t                    cfg
);
    import psdc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= data[GAIN_W-1:0];
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= data[GAIN_W-1:0];
                REG_DERIV_GAIN:  cfg_reg.deriv_gain  <= data[GAIN_W-1:0];
                REG_DUTY_CENTER: cfg_reg.duty_center <= data[DUTY_W-1:0];
                REG_DUTY_MAX:    cfg_reg.duty_max    <= data[DUTY_W-1:0];
                REG_DUTY_MIN:    cfg_reg.duty_min    <= data[DUTY_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/psdc_err.sv
// input register, error, derivative and saturating integral with loop state
`timescale 1ns / 1ps

module psdc_err (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  psdc_pkg::in_beat_t    up_beat,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output psdc_pkg::err_beat_t   dn_beat
);
    import psdc_pkg::*;

    logic                       in_valid_reg;
    in_beat_t                   in_beat_reg;
    logic                       err_valid_reg;
    err_beat_t                  err_beat_reg;
    err_beat_t                  err_beat_next;
    logic signed [ERR_W-1:0]    last_error_reg;
    logic signed [SUM_W-1:0]    error_sum_reg;

    logic                       in_ready;
    logic                       err_ready;
    logic                       err_load;
    logic signed [ERR_W-1:0]    sp;
    logic signed [ERR_W-1:0]    pos;
    logic signed [ERR_W-1:0]    err_now;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;

    assign err_ready = !err_valid_reg || dn_ready;
    assign in_ready  = !in_valid_reg || err_ready;
    assign err_load  = in_valid_reg && err_ready;
    assign up_ready  = in_ready;

    always_comb
    begin
        sp       = {1'b0, in_beat_reg.setpoint[SAMPLE_BITS-1:0]};
        pos      = {1'b0, in_beat_reg.position[SAMPLE_BITS-1:0]};
        err_now  = sp - pos;
        sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                 + {{(SUM_W + 1 - ERR_W){err_now[ERR_W-1]}}, err_now};
        // saturate when the carry disagrees with the sign
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
        err_beat_next.err   = err_now;
        err_beat_next.deriv = {err_now[ERR_W-1], err_now}
                            - {last_error_reg[ERR_W-1], last_error_reg};
        err_beat_next.sum   = sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            err_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= up_valid;
            end
            if (err_ready)
            begin
                err_valid_reg <= in_valid_reg;
            end
            if (err_load)
            begin
                last_error_reg <= err_now;
                error_sum_reg  <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && up_valid)
        begin
            in_beat_reg <= up_beat;
        end
        if (err_load)
        begin
            err_beat_reg <= err_beat_next;
        end
    end

    assign dn_valid = err_valid_reg;
    assign dn_beat  = err_beat_reg;

endmodule

### src/psdc_mult.sv
// gain multiplication stage, one registered product per term
`timescale 1ns / 1ps

module psdc_mult (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psdc_pkg::cfg_t        cfg,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  psdc_pkg::err_beat_t   up_beat,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output psdc_pkg::prod_beat_t  dn_beat
);
    import psdc_pkg::*;

    logic                        prod_valid_reg;
    prod_beat_t                  prod_beat_reg;
    prod_beat_t                  prod_beat_next;
    logic                        prod_ready;
    logic signed [GAIN_W:0]      kp_s;
    logic signed [GAIN_W:0]      ki_s;
    logic signed [GAIN_W:0]      kd_s;
    logic signed [ERR_W-1:0]     err_s;
    logic signed [SUM_W-1:0]     sum_s;
    logic signed [DERIV_W-1:0]   deriv_s;

    assign prod_ready = !prod_valid_reg || dn_ready;
    assign up_ready   = prod_ready;

    assign kp_s    = {1'b0, cfg.prop_gain};
    assign ki_s    = {1'b0, cfg.integ_gain};
    assign kd_s    = {1'b0, cfg.deriv_gain};
    assign err_s   = up_beat.err;
    assign sum_s   = up_beat.sum;
    assign deriv_s = up_beat.deriv;

    always_comb
    begin
        prod_beat_next.p_term = kp_s * err_s;
        prod_beat_next.i_term = ki_s * sum_s;
        prod_beat_next.d_term = kd_s * deriv_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            prod_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && up_valid)
        begin
            prod_beat_reg <= prod_beat_next;
        end
    end

    assign dn_valid = prod_valid_reg;
    assign dn_beat  = prod_beat_reg;

endmodule

### src/psdc_out.sv
// term sum with floor shift, then center offset, clamp and output register
`timescale 1ns / 1ps

module psdc_out #(
    parameter int GAIN_FRAC_BITS = psdc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psdc_pkg::cfg_t        cfg,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  psdc_pkg::prod_beat_t  up_beat,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output psdc_pkg::out_beat_t   dn_beat
);
    import psdc_pkg::*;

    localparam int SH_W = ACC_W - GAIN_FRAC_BITS;

    logic                       sh_valid_reg;
    logic signed [SH_W-1:0]     sh_reg;
    logic signed [SH_W-1:0]     sh_next;
    logic                       out_valid_reg;
    out_beat_t                  out_beat_reg;
    out_beat_t                  out_beat_next;

    logic                       sh_ready;
    logic                       out_ready;
    logic signed [ACC_W-1:0]    p_ext;
    logic signed [ACC_W-1:0]    i_ext;
    logic signed [ACC_W-1:0]    d_ext;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_shift;
    logic signed [SH_W:0]       duty_sum;
    logic signed [SH_W:0]       max_ext;
    logic signed [SH_W:0]       min_ext;

    assign out_ready = !out_valid_reg || dn_ready;
    assign sh_ready  = !sh_valid_reg || out_ready;
    assign up_ready  = sh_ready;

    // arithmetic shift floors toward minus infinity
    always_comb
    begin
        p_ext     = ACC_W'(up_beat.p_term);
        i_ext     = ACC_W'(up_beat.i_term);
        d_ext     = ACC_W'(up_beat.d_term);
        acc       = p_ext + i_ext + d_ext;
        acc_shift = acc >>> GAIN_FRAC_BITS;
        sh_next   = acc_shift[SH_W-1:0];
    end

    // max tested first, then min
    always_comb
    begin
        duty_sum = {sh_reg[SH_W-1], sh_reg}
                 + {{(SH_W + 1 - DUTY_W){1'b0}}, cfg.duty_center};
        max_ext  = {{(SH_W + 1 - DUTY_W){1'b0}}, cfg.duty_max};
        min_ext  = {{(SH_W + 1 - DUTY_W){1'b0}}, cfg.duty_min};
        if (duty_sum > max_ext)
        begin
            out_beat_next.duty_us = cfg.duty_max;
            out_beat_next.clamped = 1'b1;
        end
        else if (duty_sum < min_ext)
        begin
            out_beat_next.duty_us = cfg.duty_min;
            out_beat_next.clamped = 1'b1;
        end
        else
        begin
            out_beat_next.duty_us = duty_sum[DUTY_W-1:0];
            out_beat_next.clamped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sh_ready)
            begin
                sh_valid_reg <= up_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= sh_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sh_ready && up_valid)
        begin
            sh_reg <= sh_next;
        end
        if (out_ready && sh_valid_reg)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign dn_valid = out_valid_reg;
    assign dn_beat  = out_beat_reg;

endmodule

### src/psdc_checker.sv
// port-level checker for the pid servo duty controller, bound to the top level
`timescale 1ns / 1ps
`include "pid_servo_duty_controller_top_defines.svh"

module psdc_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  psdc_pkg::out_beat_t   out_beat
);
    import psdc_pkg::*;

    // pipeline empty and open while in reset
    `PSDC_ASSERT_ALWAYS(a_reset_empty, rst_n || (!out_valid && !in_stall), "not empty in reset")

    // input only backs up when every stage is full behind a stalled result
    `PSDC_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input stall without cause")

    // stalled result beat holds
    `PSDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat), "result changed under stall")

    // no input stall while nothing is offered and no result waits
    `PSDC_ASSERT_IMPL(a_idle_quiet, !in_valid && !out_valid, !in_stall, "stall while drained")

endmodule

bind pid_servo_duty_controller_top psdc_checker u_psdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
);
